// File: rtl/assert_macros.svh
// assertion macros shared by the controller and datapath rtl files of the base-38 id decoder
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define B38D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next cycle
`define B38D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define B38D_ASSERT(lbl, clk, rst_n, prop, msg)
`define B38D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/b38d_pkg.sv
// types, constants and the digit-to-ascii function of the base-38 id decoder
// no dependencies
`default_nettype none

package b38d_pkg;

  localparam int IdWidth     = 64;
  localparam int Radix       = 38;
  localparam int DigitW      = 6;
  localparam int NumDigits   = 13;
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = IdWidth / BitsPerStep;
  localparam int CntW        = $clog2(ConvSteps);
  localparam int CharW       = 7;

  localparam logic [DigitW-1:0] DigitZero = '0;
  localparam logic [DigitW-1:0] HalfRadix = DigitW'(Radix / 2);
  localparam logic [DigitW:0]   RadixSub  = (DigitW + 1)'(Radix);

  localparam logic [CharW-1:0] CharNone  = 7'h00;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharA     = 7'h61;
  localparam logic [CharW-1:0] CharUnder = 7'h5f;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b38d_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } b38d_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic emit_last;
  } b38d_sts_t;

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d >= 6'd1 && d <= 6'd10) begin
      c = CharZero + CharW'(d - 6'd1);
    end else if (d >= 6'd11 && d <= 6'd36) begin
      c = CharA + CharW'(d - 6'd11);
    end else if (d == 6'd37) begin
      c = CharUnder;
    end else begin
      c = CharNone;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b38d_ctrl.sv
// controller of the base-38 id decoder: accept, conversion count, emit sequencing
// depends on b38d_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module b38d_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output b38d_pkg::b38d_cmd_t      cmd,
  input  wire b38d_pkg::b38d_sts_t sts
);
  import b38d_pkg::*;

  b38d_state_t     state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            conv_done;

  assign conv_done = (cnt_r == CntW'(ConvSteps - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free && sts.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `B38D_ASSERT_NEXT(a_load_starts_conv, clk, rst_n, cmd.load, state_r == ST_CONV && cnt_r == '0, "load did not start conversion at step zero")
  `B38D_ASSERT_NEXT(a_conv_to_emit, clk, rst_n, state_r == ST_CONV && conv_done, state_r == ST_EMIT, "conversion did not end after the last step")
  `B38D_ASSERT_NEXT(a_last_to_idle, clk, rst_n, cmd.emit && sts.emit_last, state_r == ST_IDLE, "run did not end after its last beat")

endmodule

`default_nettype wire

// File: rtl/b38d_datapath.sv
// datapath of the base-38 id decoder: binary to base-38 digit cells and output register
// depends on b38d_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module b38d_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [b38d_pkg::IdWidth-1:0] in_encoded_id,
  input  wire b38d_pkg::b38d_cmd_t          cmd,
  output b38d_pkg::b38d_sts_t               sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [b38d_pkg::CharW-1:0]        out_char_code,
  output logic                              out_is_last,
  output logic                              out_is_error,
  output logic                              out_is_empty
);
  import b38d_pkg::*;

  logic [IdWidth-1:0]     value_r;
  logic [DigitW-1:0]      dig_r [NumDigits];
  logic [DigitW-1:0]      conv_d [BitsPerStep+1][NumDigits];
  logic                   cin [BitsPerStep][NumDigits];
  logic [DigitW:0]        dbl [BitsPerStep][NumDigits];
  logic [BitsPerStep-1:0] chunk;

  logic                   rest_zero;
  logic                   cur_zero;
  logic [CharW-1:0]       res_char;
  logic                   res_last, res_err, res_empty;

  logic                   out_valid_r;
  logic [CharW-1:0]       out_char_r;
  logic                   out_last_r, out_err_r, out_empty_r;

  assign chunk = value_r[IdWidth-1 -: BitsPerStep];

  // shift-and-add-carry over base-38 cells, one input bit per pass, msb first;
  // a cell carries out exactly when it holds 19 or more, so no ripple within a pass
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      conv_d[0][i] = dig_r[i];
    end
    for (int b = 0; b < BitsPerStep; b++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (i == 0) begin
          cin[b][i] = chunk[BitsPerStep-1-b];
        end else begin
          cin[b][i] = (conv_d[b][i-1] >= HalfRadix);
        end
        dbl[b][i] = {conv_d[b][i], cin[b][i]};
        if (conv_d[b][i] >= HalfRadix) begin
          conv_d[b+1][i] = DigitW'(dbl[b][i] - RadixSub);
        end else begin
          conv_d[b+1][i] = dbl[b][i][DigitW-1:0];
        end
      end
    end
  end

  // result for the lowest remaining digit
  always_comb begin
    rest_zero = 1'b1;
    for (int i = 1; i < NumDigits; i++) begin
      if (dig_r[i] != DigitZero) rest_zero = 1'b0;
    end
    cur_zero = (dig_r[0] == DigitZero);
    if (cur_zero && rest_zero) begin
      res_char  = CharNone;
      res_last  = 1'b1;
      res_err   = 1'b0;
      res_empty = 1'b1;
    end else if (cur_zero) begin
      res_char  = CharNone;
      res_last  = 1'b1;
      res_err   = 1'b1;
      res_empty = 1'b0;
    end else begin
      res_char  = digit_to_ascii(dig_r[0]);
      res_last  = rest_zero;
      res_err   = 1'b0;
      res_empty = 1'b0;
    end
  end

  assign sts.emit_last = res_last;
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= {1'b0, in_encoded_id[IdWidth-2:0]};
      for (int i = 0; i < NumDigits; i++) begin
        dig_r[i] <= DigitZero;
      end
    end else if (cmd.step) begin
      value_r <= value_r << BitsPerStep;
      for (int i = 0; i < NumDigits; i++) begin
        dig_r[i] <= conv_d[BitsPerStep][i];
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < NumDigits - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
      dig_r[NumDigits-1] <= DigitZero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r  <= res_char;
      out_last_r  <= res_last;
      out_err_r   <= res_err;
      out_empty_r <= res_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_is_last   = out_last_r;
  assign out_is_error  = out_err_r;
  assign out_is_empty  = out_empty_r;

  `B38D_ASSERT_NEXT(a_emit_fills_slot, clk, rst_n, cmd.emit, out_valid_r, "emitted beat not held in output register")
  `B38D_ASSERT(a_flag_ends_run, clk, rst_n, !(out_valid_r && (out_err_r || out_empty_r)) || (out_last_r && out_char_r == CharNone), "error or empty beat not last or not blank")
  `B38D_ASSERT(a_err_empty_excl, clk, rst_n, !(out_valid_r && out_err_r && out_empty_r), "beat flagged both error and empty")

endmodule

`default_nettype wire

// File: rtl/base38_id_decoder_core.sv
// base-38 identifier decoder: top level joining controller and datapath
// depends on b38d_pkg, b38d_ctrl and b38d_datapath
//
// usage:
//   in_* channel takes one 64-bit packed id per beat (bit 63 ignored).
//   out_* channel returns one beat per decoded character, least significant
//   digit first, up to 13 beats per id; out_is_last marks the final beat.
//   a zero digit inside a nonzero value ends the run with an error beat;
//   a zero id gives a single empty beat.
//   throughput: the conversion loop shifts 4 id bits per cycle into 13
//   base-38 digit cells, then one digit leaves per cycle through the
//   output register while out_ready stays high.
//   in_ready is high only between runs; the next id can be taken while the
//   final beat of the previous run still waits in the output register.
//   reset (rst_n low, synchronous) returns to idle and empties the output.
//   when the receiver stalls, the pending beat holds and the digit cells wait.
`default_nettype none

module base38_id_decoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [b38d_pkg::IdWidth-1:0] in_encoded_id,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [b38d_pkg::CharW-1:0]        out_char_code,
  output logic                              out_is_last,
  output logic                              out_is_error,
  output logic                              out_is_empty
);
  import b38d_pkg::*;

  b38d_cmd_t cmd;
  b38d_sts_t sts;

  b38d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  b38d_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_encoded_id (in_encoded_id),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last),
    .out_is_error  (out_is_error),
    .out_is_empty  (out_is_empty)
  );

endmodule

`default_nettype wire
